// File: rtl/bdq_pkg.sv
// shared types and constants for the bounded deque with search
package bdq_pkg;

	localparam logic [2:0] CMD_CLEAR      = 3'd0;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [2:0] CMD_POP_BACK   = 3'd4;
	localparam logic [2:0] CMD_SEARCH     = 3'd5;

	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned POSITION_W = 4;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned RES_W      = 2 + 1 + POSITION_W + COUNT_W;
	localparam int unsigned OUT_DATA_W = ((RES_W + 7) / 8) * 8;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_SEARCH,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_EMPTY,
		STAT_FULL
	} status_t;

	typedef enum logic {
		BS_IDLE,
		BS_SCAN
	} bstate_t;

	typedef struct packed {
		op_t                        op;
		logic signed [VALUE_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [COUNT_W-1:0]    count;
		logic [POSITION_W-1:0] position;
		logic                  found;
		status_t               status;
	} res_t;

endpackage

// File: rtl/bdq_front.sv
// front stage: takes input beats and decodes them into requests
module bdq_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bdq_pkg::VALUE_W-1:0]      s_tdata,
	input  logic [2:0]                       s_tuser,
	output logic                             q_push,
	input  logic                             q_ready,
	output bdq_pkg::req_t                    q_req
);

	logic          valid_s1;
	bdq_pkg::req_t req_s1;
	bdq_pkg::op_t  op_dec;
	logic          take;

	always_comb begin
		unique case (s_tuser)
			bdq_pkg::CMD_CLEAR:      op_dec = bdq_pkg::OP_CLEAR;
			bdq_pkg::CMD_PUSH_FRONT: op_dec = bdq_pkg::OP_PUSH_FRONT;
			bdq_pkg::CMD_PUSH_BACK:  op_dec = bdq_pkg::OP_PUSH_BACK;
			bdq_pkg::CMD_POP_FRONT:  op_dec = bdq_pkg::OP_POP_FRONT;
			bdq_pkg::CMD_POP_BACK:   op_dec = bdq_pkg::OP_POP_BACK;
			bdq_pkg::CMD_SEARCH:     op_dec = bdq_pkg::OP_SEARCH;
			default:                 op_dec = bdq_pkg::OP_NOP;
		endcase
	end

	assign s_tready = !valid_s1 || q_ready;
	assign take     = s_tvalid && s_tready;
	assign q_push   = valid_s1;
	assign q_req    = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1.op    <= op_dec;
			req_s1.value <= s_tdata;
		end
	end

endmodule

// File: rtl/bdq_fifo.sv
// short request queue between front and back
module bdq_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          ready,
	input  bdq_pkg::req_t wr_req,
	output logic          valid,
	input  logic          pop,
	output bdq_pkg::req_t rd_req
);

	bdq_pkg::req_t           slots_q [bdq_pkg::QDEPTH];
	logic [bdq_pkg::QAW-1:0] wr_ptr_q;
	logic [bdq_pkg::QAW-1:0] rd_ptr_q;
	logic [bdq_pkg::QAW:0]   fill_q;
	logic                    do_push;
	logic                    do_pop;

	assign ready   = fill_q != (bdq_pkg::QAW + 1)'(bdq_pkg::QDEPTH);
	assign valid   = fill_q != '0;
	assign do_push = push && ready;
	assign do_pop  = pop && valid;
	assign rd_req  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_req;
		end
	end

endmodule

// File: rtl/bdq_back.sv
// back end: ring storage, head and count, command execution and scan
module bdq_back #(
	parameter int unsigned DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_pop,
	input  bdq_pkg::req_t q_req,
	output logic          res_valid,
	input  logic          res_ready,
	output bdq_pkg::res_t res
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [bdq_pkg::VALUE_W-1:0] mem [DEPTH];

	bdq_pkg::bstate_t            state_q, state_n;
	logic [AW-1:0]               head_q, head_n;
	logic [CW-1:0]               count_q, count_n;
	logic                        out_valid_q;
	bdq_pkg::res_t               res_q;
	logic [AW-1:0]               slot_q, slot_n;
	logic [AW-1:0]               idx_q, idx_n;
	logic [bdq_pkg::VALUE_W-1:0] val_q;
	logic [bdq_pkg::VALUE_W-1:0] rdata_q;

	logic          slot_free;
	logic          full;
	logic          empty;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] slot_inc;
	logic [AW:0]   tail_sum;
	logic [AW-1:0] tail_slot;
	logic [CW-1:0] idx_inc;
	logic          hit;
	logic          last;

	logic                        we;
	logic [AW-1:0]               waddr;
	logic                        rd_en;
	logic [AW-1:0]               raddr;
	logic                        start_scan;
	logic                        res_load;
	bdq_pkg::status_t            res_status;
	logic                        res_found;
	logic [AW-1:0]               res_idx;
	logic [AW+bdq_pkg::POSITION_W-1:0] pos_ext;
	logic [CW+bdq_pkg::COUNT_W-1:0]    cnt_ext;

	assign slot_free = !out_valid_q || res_ready;
	assign full      = count_q == CW'(DEPTH);
	assign empty     = count_q == '0;
	assign head_inc  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
	assign slot_inc  = (slot_q == AW'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
	assign tail_sum  = {1'b0, head_q} + {1'b0, count_q[AW-1:0]};
	assign tail_slot = (tail_sum >= (AW + 1)'(DEPTH)) ? AW'(tail_sum - (AW + 1)'(DEPTH))
	                                                  : tail_sum[AW-1:0];
	assign idx_inc   = CW'(idx_q) + CW'(1);
	assign hit       = rdata_q == val_q;
	assign last      = idx_inc == count_q;

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			bdq_pkg::BS_IDLE: begin
				if (q_valid && slot_free && q_req.op == bdq_pkg::OP_SEARCH && !empty) begin
					state_n = bdq_pkg::BS_SCAN;
				end
			end
			bdq_pkg::BS_SCAN: begin
				if ((hit || last) && slot_free) begin
					state_n = bdq_pkg::BS_IDLE;
				end
			end
			default: state_n = bdq_pkg::BS_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		q_pop      = 1'b0;
		we         = 1'b0;
		waddr      = tail_slot;
		rd_en      = 1'b0;
		raddr      = slot_q;
		start_scan = 1'b0;
		res_load   = 1'b0;
		res_status = bdq_pkg::STAT_OK;
		res_found  = 1'b0;
		res_idx    = '0;
		head_n     = head_q;
		count_n    = count_q;
		slot_n     = slot_q;
		idx_n      = idx_q;
		unique case (state_q)
			bdq_pkg::BS_IDLE: begin
				if (q_valid && slot_free) begin
					q_pop    = 1'b1;
					res_load = 1'b1;
					unique case (q_req.op)
						bdq_pkg::OP_CLEAR: begin
							head_n  = '0;
							count_n = '0;
						end
						bdq_pkg::OP_PUSH_FRONT: begin
							if (full) begin
								res_status = bdq_pkg::STAT_FULL;
							end else begin
								we      = 1'b1;
								waddr   = head_dec;
								head_n  = head_dec;
								count_n = count_q + CW'(1);
							end
						end
						bdq_pkg::OP_PUSH_BACK: begin
							if (full) begin
								res_status = bdq_pkg::STAT_FULL;
							end else begin
								we      = 1'b1;
								waddr   = tail_slot;
								count_n = count_q + CW'(1);
							end
						end
						bdq_pkg::OP_POP_FRONT: begin
							if (empty) begin
								res_status = bdq_pkg::STAT_EMPTY;
							end else begin
								head_n  = head_inc;
								count_n = count_q - CW'(1);
							end
						end
						bdq_pkg::OP_POP_BACK: begin
							if (empty) begin
								res_status = bdq_pkg::STAT_EMPTY;
							end else begin
								count_n = count_q - CW'(1);
							end
						end
						bdq_pkg::OP_SEARCH: begin
							if (!empty) begin
								res_load   = 1'b0;
								start_scan = 1'b1;
								rd_en      = 1'b1;
								raddr      = head_q;
								slot_n     = head_inc;
								idx_n      = '0;
							end
						end
						default: ;
					endcase
				end
			end
			bdq_pkg::BS_SCAN: begin
				if (hit || last) begin
					if (slot_free) begin
						res_load  = 1'b1;
						res_found = hit;
						res_idx   = hit ? idx_q : '0;
					end
				end else begin
					rd_en  = 1'b1;
					raddr  = slot_q;
					slot_n = slot_inc;
					idx_n  = idx_inc[AW-1:0];
				end
			end
			default: ;
		endcase
	end

	assign pos_ext = {{bdq_pkg::POSITION_W{1'b0}}, res_idx};
	assign cnt_ext = {{bdq_pkg::COUNT_W{1'b0}}, count_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdq_pkg::BS_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			head_q  <= head_n;
			count_q <= count_n;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_n;
		idx_q  <= idx_n;
		if (start_scan) begin
			val_q <= q_req.value;
		end
		if (res_load) begin
			res_q.status   <= res_status;
			res_q.found    <= res_found;
			res_q.position <= pos_ext[bdq_pkg::POSITION_W-1:0];
			res_q.count    <= cnt_ext[bdq_pkg::COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= q_req.value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

endmodule

// File: rtl/bounded_deque_with_search_core.sv
// top level of the bounded deque with linear search
// Commands arrive as beats on the s_ side and each gives exactly one result beat on the m_ side,
// in order. The entries sit in a single-port ring memory of DEPTH words. Clear, push and pop are
// executed from the back end's idle state; a search reads one entry per cycle from the head and
// stops at the first match or after the last entry. A front register and a two-entry queue keep
// taking beats while the back end scans or a result waits. A non-search command passes the front
// register and the queue before the back end registers its result.
module bounded_deque_with_search_core #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bdq_pkg::VALUE_W-1:0]       s_tdata,  // value
	input  logic [2:0]                        s_tuser,  // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bdq_pkg::OUT_DATA_W-1:0]    m_tdata   // status, found, position, count
);

	logic          q_push;
	logic          q_ready;
	bdq_pkg::req_t q_wr_req;
	logic          q_valid;
	logic          q_pop;
	bdq_pkg::req_t q_rd_req;
	bdq_pkg::res_t res;

	bdq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_push   (q_push),
		.q_ready  (q_ready),
		.q_req    (q_wr_req)
	);

	bdq_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.ready  (q_ready),
		.wr_req (q_wr_req),
		.valid  (q_valid),
		.pop    (q_pop),
		.rd_req (q_rd_req)
	);

	bdq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_req     (q_rd_req),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {{(bdq_pkg::OUT_DATA_W - bdq_pkg::RES_W){1'b0}}, res};

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped an empty queue");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res.status == bdq_pkg::STAT_OK || res.status == bdq_pkg::STAT_EMPTY ||
		             res.status == bdq_pkg::STAT_FULL)
		else $error("result status out of range");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.found |-> res.status == bdq_pkg::STAT_OK)
		else $error("search hit with failure status");

	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.found |-> res.position == '0)
		else $error("nonzero position without a match");

endmodule
